FILE: rtl/dap_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dap_pkg
// Shared types and constants of the decimal amount parser: status codes,
// parse phases, character codes and the powers-of-ten table.
// ----------------------------------------------------------------------------
package dap_pkg;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_WHOLE_OVF = 3'd1,
    ST_INVALID   = 3'd2,
    ST_EMPTY     = 3'd3,
    ST_SCALE_OVF = 3'd4,
    ST_ADD_OVF   = 3'd5
  } status_e;

  typedef enum logic [1:0] {
    PH_LEAD  = 2'd0,
    PH_WHOLE = 2'd1,
    PH_FRAC  = 2'd2,
    PH_TRAIL = 2'd3
  } phase_e;

  // register index, taken from the 8-byte word address
  localparam logic REG_MAX_AMOUNT = 1'b0;

  localparam logic [63:0] MAX_AMOUNT_RESET = 64'hFFFF_FFFF_FFFF_FFFF;

  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_POINT = 8'h2E;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0D;

  localparam int POW10_N = 20;

  localparam logic [63:0] POW10 [POW10_N] = '{
    64'd1,
    64'd10,
    64'd100,
    64'd1000,
    64'd10000,
    64'd100000,
    64'd1000000,
    64'd10000000,
    64'd100000000,
    64'd1000000000,
    64'd10000000000,
    64'd100000000000,
    64'd1000000000000,
    64'd10000000000000,
    64'd100000000000000,
    64'd1000000000000000,
    64'd10000000000000000,
    64'd100000000000000000,
    64'd1000000000000000000,
    64'd10000000000000000000
  };

endpackage

FILE: rtl/dap_finish.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dap_finish
// Result pipeline: scales the whole part, adds the fraction and checks the
// total against the limit. Four elastic stages, each with its own valid bit.
// ----------------------------------------------------------------------------
module dap_finish #(
  parameter int          FRAC_W = 27,
  parameter logic [63:0] MULT   = 64'd100000000
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 load_i,
  output logic                 free_o,
  input  dap_pkg::status_e     status_i,
  input  logic [63:0]          whole_i,
  input  logic [FRAC_W-1:0]    frac_i,
  input  logic [63:0]          max_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic [63:0]          out_amount_o,
  output dap_pkg::status_e     out_status_o
);

  localparam logic [31:0] MULT_LO = MULT[31:0];
  localparam logic [31:0] MULT_HI = MULT[63:32];

  logic                s1_valid_q;
  dap_pkg::status_e    s1_status_q;
  logic [63:0]         s1_whole_q;
  logic [FRAC_W-1:0]   s1_frac_q;

  logic                s2_valid_q;
  dap_pkg::status_e    s2_status_q;
  logic [FRAC_W-1:0]   s2_frac_q;
  logic [63:0]         p_ll_q, p_lh_q, p_hl_q, p_hh_q;

  logic                s3_valid_q;
  dap_pkg::status_e    s3_status_q;
  logic [FRAC_W-1:0]   s3_frac_q;
  logic [127:0]        prod_q;
  logic [127:0]        prod_d;

  logic                out_valid_q;
  logic [63:0]         amount_q, amount_d;
  dap_pkg::status_e    status_q, status_d;
  logic [64:0]         sum;

  logic out_free, s3_free, s2_free, s1_free;

  assign out_free = !out_valid_q || !out_stall_i;
  assign s3_free  = !s3_valid_q || out_free;
  assign s2_free  = !s2_valid_q || s3_free;
  assign s1_free  = !s1_valid_q || s2_free;
  assign free_o   = s1_free;

  assign prod_d = 128'(p_ll_q) + (128'(p_lh_q) << 32) + (128'(p_hl_q) << 32)
                + (128'(p_hh_q) << 64);

  assign sum = 65'(prod_q[63:0]) + 65'(s3_frac_q);

  always_comb begin
    amount_d = '0;
    status_d = s3_status_q;
    if (s3_status_q == dap_pkg::ST_OK) begin
      if ((|prod_q[127:64]) || (prod_q[63:0] > max_i)) begin
        status_d = dap_pkg::ST_SCALE_OVF;
      end else if (sum > 65'(max_i)) begin
        status_d = dap_pkg::ST_ADD_OVF;
      end else begin
        amount_d = sum[63:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      s2_valid_q  <= 1'b0;
      s3_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (s1_free)  s1_valid_q  <= load_i;
      if (s2_free)  s2_valid_q  <= s1_valid_q;
      if (s3_free)  s3_valid_q  <= s2_valid_q;
      if (out_free) out_valid_q <= s3_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_free && load_i) begin
      s1_status_q <= status_i;
      s1_whole_q  <= whole_i;
      s1_frac_q   <= frac_i;
    end
    if (s2_free && s1_valid_q) begin
      s2_status_q <= s1_status_q;
      s2_frac_q   <= s1_frac_q;
      p_ll_q      <= s1_whole_q[31:0]  * MULT_LO;
      p_lh_q      <= s1_whole_q[31:0]  * MULT_HI;
      p_hl_q      <= s1_whole_q[63:32] * MULT_LO;
      p_hh_q      <= s1_whole_q[63:32] * MULT_HI;
    end
    if (s3_free && s2_valid_q) begin
      s3_status_q <= s2_status_q;
      s3_frac_q   <= s2_frac_q;
      prod_q      <= prod_d;
    end
    if (out_free && s3_valid_q) begin
      amount_q <= amount_d;
      status_q <= status_d;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign out_amount_o = amount_q;
  assign out_status_o = status_q;

endmodule

FILE: rtl/decimal_amount_parser_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// decimal_amount_parser_unit
// Parses a decimal amount string, one character per item, into a fixed-point
// amount with DECIMALS fraction digits, checked against max_amount.
// ----------------------------------------------------------------------------
// The block takes one item per cycle unless stalled, characters and end
// markers alike. Each character updates the parse state in the cycle it is
// accepted; an end marker snapshots that state, clears it, and sends the
// snapshot down a four-stage result pipeline (capture, split 32-bit partial
// products, product sum, limit checks), whose last stage registers the result.
// The pipeline is elastic, so input is held off only when all four stages are
// full behind a stalled output. max_amount sits at byte address 0; the user is
// to write it only while no result is pending, and the block does not enforce it.
module decimal_amount_parser_unit #(
  parameter int DECIMALS = 8
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  in_ch_i,
  input  logic        in_end_req_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [63:0] out_amount_o,
  output logic [2:0]  out_status_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [63:0] pwdata,
  output logic [63:0] prdata,
  output logic        pready
);

  localparam logic [63:0] MULT   = dap_pkg::POW10[DECIMALS];
  localparam int          FRAC_W = $clog2(MULT);
  localparam int          CNT_W  = $clog2(DECIMALS + 1);

  logic [63:0]        max_q;
  dap_pkg::phase_e    phase_q, phase_d;
  dap_pkg::status_e   err_q, err_d;
  logic [63:0]        whole_q, whole_d;
  logic [FRAC_W-1:0]  frac_q, frac_d;
  logic [CNT_W-1:0]   cnt_q, cnt_d;

  logic               in_accept;
  logic               fin_free;
  logic               fin_load;
  dap_pkg::status_e   head_status;
  dap_pkg::status_e   fin_status;

  logic               is_ws, is_dig, is_point;
  logic [3:0]         digit;
  logic [67:0]        whole_x10;
  logic               whole_ovf;
  logic [4:0]         pow_idx;
  logic [63:0]        frac_step;

  // configuration port
  assign pready = 1'b1;
  assign prdata = (paddr[3] == dap_pkg::REG_MAX_AMOUNT) ? max_q : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_q <= dap_pkg::MAX_AMOUNT_RESET;
    end else if (psel && penable && pwrite && pready
                 && paddr[3] == dap_pkg::REG_MAX_AMOUNT) begin
      max_q <= pwdata;
    end
  end

  // character classes
  assign is_dig   = (in_ch_i >= dap_pkg::CH_ZERO) && (in_ch_i <= dap_pkg::CH_NINE);
  assign is_ws    = (in_ch_i == dap_pkg::CH_SPACE)
                 || ((in_ch_i >= dap_pkg::CH_TAB) && (in_ch_i <= dap_pkg::CH_CR));
  assign is_point = (in_ch_i == dap_pkg::CH_POINT);
  assign digit    = in_ch_i[3:0];

  assign whole_x10 = 68'({whole_q, 3'b000}) + 68'({whole_q, 1'b0}) + 68'(digit);
  assign whole_ovf = |whole_x10[67:64];

  // weight of the next fraction digit
  assign pow_idx   = 5'(DECIMALS - 1) - 5'(cnt_q);
  assign frac_step = 64'(digit) * dap_pkg::POW10[pow_idx];

  assign in_accept  = in_valid_i && !in_stall_o;
  assign in_stall_o = !fin_free;
  assign fin_load   = in_accept && in_end_req_i;

  always_comb begin
    priority if (err_q != dap_pkg::ST_OK) head_status = err_q;
    else if (phase_q == dap_pkg::PH_LEAD) head_status = dap_pkg::ST_EMPTY;
    else head_status = dap_pkg::ST_OK;
  end

  always_comb begin
    phase_d = phase_q;
    err_d   = err_q;
    whole_d = whole_q;
    frac_d  = frac_q;
    cnt_d   = cnt_q;
    if (in_accept) begin
      if (in_end_req_i) begin
        phase_d = dap_pkg::PH_LEAD;
        err_d   = dap_pkg::ST_OK;
        whole_d = '0;
        frac_d  = '0;
        cnt_d   = '0;
      end else if (err_q == dap_pkg::ST_OK) begin
        unique case (phase_q)
          dap_pkg::PH_LEAD, dap_pkg::PH_WHOLE: begin
            if (is_dig) begin
              if (whole_ovf) begin
                err_d = dap_pkg::ST_WHOLE_OVF;
              end else begin
                whole_d = whole_x10[63:0];
                phase_d = dap_pkg::PH_WHOLE;
              end
            end else if (is_point) begin
              phase_d = dap_pkg::PH_FRAC;
            end else if (is_ws) begin
              if (phase_q == dap_pkg::PH_WHOLE) phase_d = dap_pkg::PH_TRAIL;
            end else begin
              err_d = dap_pkg::ST_INVALID;
            end
          end
          dap_pkg::PH_FRAC: begin
            if (is_dig) begin
              if (cnt_q < CNT_W'(DECIMALS)) begin
                frac_d = frac_q + frac_step[FRAC_W-1:0];
                cnt_d  = cnt_q + CNT_W'(1);
              end
            end else if (is_ws) begin
              phase_d = dap_pkg::PH_TRAIL;
            end else begin
              err_d = dap_pkg::ST_INVALID;
            end
          end
          dap_pkg::PH_TRAIL: begin
            if (!is_ws) err_d = dap_pkg::ST_INVALID;
          end
          default: begin
            err_d = err_q;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= dap_pkg::PH_LEAD;
      err_q   <= dap_pkg::ST_OK;
      whole_q <= '0;
      frac_q  <= '0;
      cnt_q   <= '0;
    end else begin
      phase_q <= phase_d;
      err_q   <= err_d;
      whole_q <= whole_d;
      frac_q  <= frac_d;
      cnt_q   <= cnt_d;
    end
  end

  dap_finish #(
    .FRAC_W (FRAC_W),
    .MULT   (MULT)
  ) u_finish (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .load_i       (fin_load),
    .free_o       (fin_free),
    .status_i     (head_status),
    .whole_i      (whole_q),
    .frac_i       (frac_q),
    .max_i        (max_q),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .out_amount_o (out_amount_o),
    .out_status_o (fin_status)
  );

  assign out_status_o = fin_status;

`ifndef SYNTH
  a_amount_zero_on_error: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && fin_status != dap_pkg::ST_OK |-> out_amount_o == '0)
    else $error("nonzero amount with error status");

  a_amount_within_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && fin_status == dap_pkg::ST_OK |-> out_amount_o <= max_q)
    else $error("amount above limit reported ok");

  a_clear_after_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fin_load |=> phase_q == dap_pkg::PH_LEAD && err_q == dap_pkg::ST_OK
                 && whole_q == '0 && frac_q == '0 && cnt_q == '0)
    else $error("parse state not cleared after end item");

  a_frac_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q != dap_pkg::PH_FRAC && phase_q != dap_pkg::PH_TRAIL |-> cnt_q == '0)
    else $error("fraction digits counted outside fraction");
`endif

endmodule
